// ----- design/sste_pkg.sv -----
// ----------------------------------------------------------------------------
// sste_pkg: shared types and constants of the sorted software timer engine
// Holds the widths, command codes and the divider request and answer types.
// ----------------------------------------------------------------------------
package sste_pkg;

   localparam int FUNC_BITS = 2;
   localparam int ID_BITS   = 4;
   localparam int IVAL_BITS = 32;
   localparam int MPT_BITS  = 16;
   localparam logic [MPT_BITS-1:0] MPT_RESET = 16'd10;

   typedef enum logic [FUNC_BITS-1:0] {
      FUNC_TICK  = 2'd0,
      FUNC_SET   = 2'd1,
      FUNC_START = 2'd2,
      FUNC_STOP  = 2'd3
   } func_type;

   // divider request and answer
   typedef struct packed {
      logic                 start;
      logic [IVAL_BITS-1:0] dividend;
      logic [MPT_BITS-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [IVAL_BITS:0]   quotient;
   } div_rsp_type;

endpackage

// ----- design/sste_divider.sv -----
// ----------------------------------------------------------------------------
// sste_divider: restoring divider
// Computes ceil(dividend / divisor) one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sste_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  sste_pkg::div_req_type req,
   output sste_pkg::div_rsp_type rsp
);
   import sste_pkg::*;

   localparam int NB = IVAL_BITS + MPT_BITS; // numerator width after rounding offset
   localparam int CB = $clog2(NB + 1);

   logic [NB-1:0]      num_ff, num_in;
   logic [MPT_BITS:0]  rem_ff, rem_in;
   logic [MPT_BITS-1:0] dsr_ff, dsr_in;
   logic [CB-1:0]      cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [MPT_BITS+1:0] trial;

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, num_ff[NB-1]} - {2'b00, dsr_ff};
      if (req.start) begin
         // ceil via (n + d - 1) / d
         num_in  = NB'(req.dividend) + NB'(req.divisor) - NB'(1);
         dsr_in  = req.divisor;
         rem_in  = '0;
         cnt_in  = CB'(NB);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[MPT_BITS+1]) begin
            rem_in = trial[MPT_BITS:0];
            num_in = {num_ff[NB-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[MPT_BITS-1:0], num_ff[NB-1]};
            num_in = {num_ff[NB-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CB'(1);
         if (cnt_ff == CB'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = num_ff[IVAL_BITS:0];

endmodule

// ----- design/sorted_software_timer_engine.sv -----
// ----------------------------------------------------------------------------
// sorted_software_timer_engine: ordered one-shot timer list
// Timer bank with a sorted expiry list walked by a small sequencer.
// ----------------------------------------------------------------------------
// a set with a nonzero interval runs the divider, one quotient bit per cycle;
// start and stop walk the list one entry per cycle; a tick walks the expired
// front entries one per cycle and then emits one item per cycle while rsp_tready
// is high. one command is in work at a time; req_tready is low meanwhile.
// reset clears time, durations, running flags and the list count.
module sorted_software_timer_engine #(
   parameter int NUM_SLOTS = 16,
   parameter int TIME_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // func[1:0], slot_id[5:2], interval_ms[37:6]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // expired_id[3:0]
   output logic        rsp_tlast,  // last_expired
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import sste_pkg::*;

   localparam int SB = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CB = $clog2(NUM_SLOTS + 1);
   localparam logic [TIME_BITS-1:0] DUR_MAX = {1'b0, {(TIME_BITS-1){1'b1}}};

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_DIV    = 8'b0000_0010,
      ST_FIND   = 8'b0000_0100,
      ST_SHL    = 8'b0000_1000,
      ST_SEEK   = 8'b0001_0000,
      ST_SHR    = 8'b0010_0000,
      ST_EXPIRE = 8'b0100_0000,
      ST_EMIT   = 8'b1000_0000
   } state_type;

   state_type           state_ff, state_in;
   logic [MPT_BITS-1:0] mpt_ff, mpt_in;
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic [TIME_BITS-1:0] dur_ff [NUM_SLOTS];
   logic [TIME_BITS-1:0] exp_ff [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] run_ff, run_in;
   logic [SB-1:0]       list_ff [NUM_SLOTS];
   logic [CB-1:0]       cnt_ff, cnt_in;
   logic [CB-1:0]       idx_ff, idx_in;
   logic [CB-1:0]       nexp_ff, nexp_in;
   logic [CB-1:0]       drop_ff, drop_in;
   func_type            func_ff, func_in;
   logic [ID_BITS-1:0]  sid_ff, sid_in;
   logic [TIME_BITS-1:0] nexp_time_ff, nexp_time_in;
   logic [SB-1:0]       gone_ff [NUM_SLOTS];
   logic                rv_ff, rv_in;

   // list edits decided in comb logic
   logic                lw_en, dw_en, ew_en, gw_en;
   logic [SB-1:0]       lw_idx, lw_val, dw_idx, ew_idx, gw_idx;
   logic [TIME_BITS-1:0] dw_val, ew_val;

   div_req_type dreq;
   div_rsp_type drsp;

   logic [SB-1:0] sid_s, idx_s, idx_m1;
   logic [SB-1:0] head_id;
   logic [TIME_BITS-1:0] diff;
   logic          in_bank;
   logic          acc;
   logic          cfg_wr;

   sste_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   assign sid_s   = SB'(sid_ff);
   assign idx_s   = idx_ff[SB-1:0];
   assign idx_m1  = SB'(idx_ff - CB'(1));
   assign in_bank = (32'(req_tdata[5:2]) < NUM_SLOTS);
   assign acc     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE) && !rv_ff;
   assign cfg_wr  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == 2'd0) ? 32'(mpt_ff) : 32'd0;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = 8'(gone_ff[SB'(nexp_ff - CB'(1))]);
   assign rsp_tlast  = (nexp_ff == CB'(1));
   assign head_id    = list_ff[idx_s];

   always_comb begin
      state_in     = state_ff;
      mpt_in       = cfg_wr && (csr_paddr == 2'd0) ? csr_pwdata[MPT_BITS-1:0] : mpt_ff;
      now_in       = now_ff;
      run_in       = run_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      nexp_in      = nexp_ff;
      drop_in      = drop_ff;
      func_in      = func_ff;
      sid_in       = sid_ff;
      nexp_time_in = nexp_time_ff;
      rv_in        = rv_ff;
      lw_en = 1'b0; lw_idx = '0; lw_val = '0;
      dw_en = 1'b0; dw_idx = sid_s; dw_val = '0;
      ew_en = 1'b0; ew_idx = sid_s; ew_val = nexp_time_ff;
      gw_en = 1'b0; gw_idx = nexp_ff[SB-1:0];
      dreq.start    = 1'b0;
      dreq.dividend = req_tdata[37:6];
      dreq.divisor  = (mpt_ff == '0) ? MPT_BITS'(1) : mpt_ff;
      diff = '0;
      case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               func_in = func_type'(req_tdata[1:0]);
               sid_in  = req_tdata[5:2];
               idx_in  = '0;
               nexp_in = '0;
               if (func_type'(req_tdata[1:0]) == FUNC_TICK) begin
                  now_in   = now_ff + TIME_BITS'(1);
                  state_in = ST_EXPIRE;
               end else if (in_bank) begin
                  case (func_type'(req_tdata[1:0]))
                     FUNC_SET: begin
                        if (req_tdata[37:6] == '0) begin
                           dw_en = 1'b1;
                           dw_idx = SB'(req_tdata[5:2]);
                        end else begin
                           dreq.start = 1'b1;
                           state_in   = ST_DIV;
                        end
                     end
                     default: state_in = ST_FIND;
                  endcase
               end
            end
         end
         ST_DIV: begin
            if (drsp.done) begin
               dw_en = 1'b1;
               if (drsp.quotient >= 33'(DUR_MAX) - 33'd1) dw_val = DUR_MAX;
               else dw_val = TIME_BITS'(drsp.quotient + 33'd1);
               state_in = ST_IDLE;
            end
         end
         ST_FIND: begin
            // locate running slot in the list, then close the gap
            if (!run_ff[sid_s] || idx_ff >= cnt_ff) begin
               run_in[sid_s] = 1'b0;
               idx_in = '0;
               nexp_time_in = now_ff + dur_ff[sid_s];
               if (func_ff == FUNC_START && dur_ff[sid_s] != '0) state_in = ST_SEEK;
               else state_in = ST_IDLE;
            end else if (head_id == sid_s) begin
               state_in = ST_SHL;
            end else begin
               idx_in = idx_ff + CB'(1);
            end
         end
         ST_SHL: begin
            if (idx_ff + CB'(1) >= cnt_ff) begin
               cnt_in = cnt_ff - CB'(1);
               run_in[sid_s] = 1'b0;
               idx_in = '0;
               nexp_time_in = now_ff + dur_ff[sid_s];
               if (func_ff == FUNC_START && dur_ff[sid_s] != '0) state_in = ST_SEEK;
               else state_in = ST_IDLE;
            end else begin
               lw_en = 1'b1; lw_idx = idx_s; lw_val = list_ff[SB'(idx_ff + CB'(1))];
               idx_in = idx_ff + CB'(1);
            end
         end
         ST_SEEK: begin
            diff = exp_ff[head_id] - nexp_time_ff;
            if (idx_ff >= cnt_ff || !diff[TIME_BITS-1]) begin
               nexp_in  = idx_ff;   // insertion point
               idx_in   = cnt_ff;
               ew_en    = 1'b1;
               run_in[sid_s] = 1'b1;
               state_in = ST_SHR;
            end else begin
               idx_in = idx_ff + CB'(1);
            end
         end
         ST_SHR: begin
            lw_en = 1'b1; lw_idx = idx_s;
            if (idx_ff == nexp_ff) begin
               lw_val   = sid_s;
               cnt_in   = cnt_ff + CB'(1);
               nexp_in  = '0;
               state_in = ST_IDLE;
            end else begin
               lw_val = list_ff[idx_m1];
               idx_in = idx_ff - CB'(1);
            end
         end
         ST_EXPIRE: begin
            diff = now_ff - exp_ff[head_id];
            if (idx_ff < cnt_ff && !diff[TIME_BITS-1]) begin
               gw_en = 1'b1; gw_idx = idx_s;
               run_in[head_id] = 1'b0;
               idx_in  = idx_ff + CB'(1);
               nexp_in = idx_ff + CB'(1);
            end else if (idx_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               // compact the list by the number removed
               drop_in  = idx_ff;
               cnt_in   = cnt_ff - idx_ff;
               idx_in   = '0;
               state_in = ST_EMIT;
               rv_in    = 1'b1;
            end
         end
         ST_EMIT: begin
            if (idx_ff < cnt_ff) begin
               lw_en = 1'b1; lw_idx = idx_s;
               lw_val = list_ff[SB'(idx_ff + drop_ff)];
               idx_in = idx_ff + CB'(1);
            end
            if (rv_ff && rsp_tready) begin
               nexp_in = nexp_ff - CB'(1);
               if (nexp_ff == CB'(1)) rv_in = 1'b0;
            end
            if (!rv_in && !(idx_ff < cnt_ff)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mpt_ff   <= MPT_RESET;
         now_ff   <= '0;
         run_ff   <= '0;
         cnt_ff   <= '0;
         rv_ff    <= 1'b0;
         for (int i = 0; i < NUM_SLOTS; i++) dur_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         mpt_ff   <= mpt_in;
         now_ff   <= now_in;
         run_ff   <= run_in;
         cnt_ff   <= cnt_in;
         rv_ff    <= rv_in;
         if (dw_en) dur_ff[dw_idx] <= dw_val;
      end
      idx_ff       <= idx_in;
      nexp_ff      <= nexp_in;
      drop_ff      <= drop_in;
      func_ff      <= func_in;
      sid_ff       <= sid_in;
      nexp_time_ff <= nexp_time_in;
      if (lw_en) list_ff[lw_idx] <= lw_val;
      if (ew_en) exp_ff[ew_idx] <= ew_val;
      if (gw_en) gone_ff[gw_idx] <= head_id;
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CB'(NUM_SLOTS)) else $error("list count beyond bank");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == ST_IDLE) else $error("ready while busy");
   a_rsp_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> state_ff == ST_EMIT) else $error("item outside emit");
   a_run_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> $countones(run_ff) == 32'(cnt_ff))
      else $error("running flags disagree with list");

endmodule

// ----- tb/sorted_software_timer_engine_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_software_timer_engine_tb: self-checking bench of the timer engine
// Drives set, start, stop and tick commands with random gaps on both streams,
// predicts the expired slot ids of every tick, and checks them in order.
// ----------------------------------------------------------------------------
module sorted_software_timer_engine_tb;
   import sste_pkg::*;

   localparam int SLOTS      = 16;
   localparam int MAX_EXPIRE = 16;
   localparam int WD_LIMIT   = 4000;
   localparam logic [31:0] DUR_SAT = 32'h7FFF_FFFF;
   localparam logic [1:0]  REG_MS_PER_TICK = 2'd0;

   // timer list predictor and store of pending expiries
   class timer_scoreboard;
      logic [15:0] ms_per_tick;
      logic [31:0] now_ticks;
      logic [31:0] duration [SLOTS];
      logic [31:0] expiry [SLOTS];
      bit          running [SLOTS];
      logic [3:0]  order_q [$];
      logic [4:0]  expired_q [$];  // {last, id}
      int          mismatches;

      function new();
         ms_per_tick = MPT_RESET;
         now_ticks   = '0;
         for (int i = 0; i < SLOTS; i++) begin
            duration[i] = '0;
            running[i]  = 1'b0;
         end
         mismatches = 0;
      endfunction

      function bit reached(logic [31:0] a, logic [31:0] b);
         logic [31:0] d;
         d = a - b;
         return !d[31];
      endfunction

      function void drop_slot(int s);
         if (!running[s]) return;
         foreach (order_q[i]) begin
            if (order_q[i] == s) begin
               order_q.delete(i);
               break;
            end
         end
         running[s] = 1'b0;
      endfunction

      function void note_command(func_type fn, logic [3:0] s, logic [31:0] ival);
         logic [63:0] m, d;
         int          pos, n;
         logic [3:0]  gone [$];
         case (fn)
            FUNC_TICK: begin
               now_ticks = now_ticks + 1;
               n = 0;
               while (order_q.size() > 0 && n < MAX_EXPIRE &&
                      reached(now_ticks, expiry[order_q[0]])) begin
                  gone.push_back(order_q[0]);
                  running[order_q[0]] = 1'b0;
                  order_q.pop_front();
                  n++;
               end
               for (int i = n - 1; i >= 0; i--)
                  expired_q.push_back({i == 0, gone[i]});
            end
            FUNC_SET: begin
               m = (ms_per_tick == 0) ? 64'd1 : {48'd0, ms_per_tick};
               d = 0;
               if (ival != 0) begin
                  d = 1 + ({32'd0, ival} + m - 1) / m;
                  if (d > {32'd0, DUR_SAT}) d = {32'd0, DUR_SAT};
               end
               duration[s] = d[31:0];
            end
            FUNC_START: begin
               drop_slot(s);
               if (duration[s] != 0 && order_q.size() < SLOTS) begin
                  expiry[s]  = now_ticks + duration[s];
                  running[s] = 1'b1;
                  pos = order_q.size();
                  foreach (order_q[i]) begin
                     if (reached(expiry[order_q[i]], expiry[s])) begin
                        pos = i;
                        break;
                     end
                  end
                  order_q.insert(pos, s);
               end
            end
            default: drop_slot(s);
         endcase
      endfunction

      function void check_expiry(logic [3:0] id, logic last);
         logic [4:0] want;
         if (expired_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected expiry id=%0d last=%0b", $realtime, id, last);
            return;
         end
         want = expired_q.pop_front();
         if (want[3:0] !== id || want[4] !== last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: expiry mismatch: expected id=%0d last=%0b, got id=%0d last=%0b",
                        $realtime, want[3:0], want[4], id, last);
         end
      endfunction

      function int pending();
         return expired_q.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [1:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   timer_scoreboard timers;
   bit  idle_on;
   bit  hold_kick;
   int  hold_left;
   int  quiet_cycles;
   bit  csr_hit;

   sorted_software_timer_engine dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      clock = 1'b1; #10;
      clock = 1'b0; #10;
   end

   // result side: random stalls, a long hold on request, and checking
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            timers.check_expiry(rsp_tdata[3:0], rsp_tlast);
         if (hold_kick) begin
            hold_kick = 1'b0;
            hold_left = 700;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!rsp_tready) begin
            rsp_tready <= 1'b1;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            hold_left = $urandom_range(0, 11);
         end
      end
   end

   // watchdog on cycles without any accepted item
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_hit)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WD_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // called at a rising edge; returns at the edge the item is accepted
   task automatic send_cmd(func_type fn, logic [3:0] s, logic [31:0] ival);
      int gap;
      gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, ival, s, fn};
      do @(posedge clock); while (!req_tready);
      timers.note_command(fn, s, ival);
   endtask

   // only while idle: drain expiries, let a last command finish, then write
   task automatic write_ms_per_tick(logic [15:0] value);
      req_tvalid <= 1'b0;
      while (timers.pending() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      csr_psel   <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr  <= REG_MS_PER_TICK;
      csr_pwdata <= {16'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      csr_hit     <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_hit     <= 1'b0;
      timers.ms_per_tick = value;
   endtask

   function automatic logic [31:0] pick_interval();
      logic [31:0] m;
      m = (timers.ms_per_tick == 0) ? 32'd1 : {16'd0, timers.ms_per_tick};
      case ($urandom_range(0, 19))
         0:       return 32'd0;
         1:       return $urandom;
         2:       return 32'hFFFF_FFFF;
         default: return $urandom_range(1, 6 * m);
      endcase
   endfunction

   task automatic random_cmds(int count);
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 38)
            send_cmd(FUNC_TICK, 4'($urandom_range(0, 15)), $urandom);
         else if (r < 62)
            send_cmd(FUNC_SET, 4'($urandom_range(0, 15)), pick_interval());
         else if (r < 88)
            send_cmd(FUNC_START, 4'($urandom_range(0, 15)), $urandom);
         else
            send_cmd(FUNC_STOP, 4'($urandom_range(0, 15)), $urandom);
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      rsp_tready  = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      csr_hit     = 1'b0;
      idle_on     = 1'b1;
      hold_kick   = 1'b0;
      hold_left   = 0;
      timers      = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero and all-ones intervals, equal expiries, restart, idle stop
      send_cmd(FUNC_SET, 4'd0, 32'd0);
      send_cmd(FUNC_START, 4'd0, 32'd0);
      send_cmd(FUNC_SET, 4'd15, 32'hFFFF_FFFF);
      send_cmd(FUNC_START, 4'd15, 32'd0);
      send_cmd(FUNC_SET, 4'd1, 32'd10);
      send_cmd(FUNC_SET, 4'd2, 32'd7);
      send_cmd(FUNC_SET, 4'd3, 32'd25);
      send_cmd(FUNC_START, 4'd1, 32'd0);
      send_cmd(FUNC_START, 4'd2, 32'd0);
      send_cmd(FUNC_START, 4'd3, 32'd0);
      send_cmd(FUNC_STOP, 4'd9, 32'hFFFF_FFFF);
      send_cmd(FUNC_TICK, 4'd0, 32'd0);
      send_cmd(FUNC_START, 4'd1, 32'd0);
      send_cmd(FUNC_TICK, 4'd15, 32'hFFFF_FFFF);
      send_cmd(FUNC_TICK, 4'd0, 32'd0);
      send_cmd(FUNC_STOP, 4'd3, 32'd0);
      send_cmd(FUNC_TICK, 4'd0, 32'd0);
      send_cmd(FUNC_TICK, 4'd0, 32'd0);
      send_cmd(FUNC_STOP, 4'd15, 32'd0);
      send_cmd(FUNC_SET, 4'd14, 32'hAAAA_5555);
      send_cmd(FUNC_SET, 4'd14, 32'h5555_AAAA);
      send_cmd(FUNC_TICK, 4'd0, 32'd0);
      random_cmds(60);

      // one tick per ms: many slots share expiries; long result stall here
      write_ms_per_tick(16'd1);
      for (int s = 0; s < SLOTS; s++) send_cmd(FUNC_SET, 4'(s), 32'd2);
      for (int s = 0; s < SLOTS; s++) send_cmd(FUNC_START, 4'(s), 32'd0);
      hold_kick = 1'b1;
      repeat (4) send_cmd(FUNC_TICK, 4'd0, 32'd0);
      random_cmds(100);

      write_ms_per_tick(16'hFFFF);
      random_cmds(80);

      write_ms_per_tick(16'd0);
      random_cmds(80);

      write_ms_per_tick(16'($urandom_range(2, 300)));
      random_cmds(60);
      idle_on = 1'b0;
      random_cmds(40);

      req_tvalid <= 1'b0;
      while (timers.pending() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (timers.mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
